// File: rtl/gbm_pkg.sv
// Package for the GBM path step block: word format, register codes and the
// saturating fixed-point multiply shared by the datapath. No dependencies.
package gbm_pkg;

    // Word format: signed Q12.20 in 32 bits
    localparam int WORD_W = 32;
    localparam int FRAC_W = 20;
    localparam int PROD_W = 2 * WORD_W;
    localparam int QUOT_W = PROD_W - FRAC_W;

    typedef logic signed [WORD_W-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    // 0.5 in the word format
    localparam t_word HALF     = t_word'(1) <<< (FRAC_W - 1);

    // Configuration register widths and reset values
    localparam int DT_W    = 21;
    localparam int RATE_W  = 22;
    localparam int VOL_W   = 23;
    localparam int SPOT_W  = 31;
    localparam int CFG_W   = 31;
    localparam int CADDR_W = 3;
    localparam logic [SPOT_W-1:0] SPOT_RESET = SPOT_W'(1) << FRAC_W;

    typedef enum logic [CADDR_W-1:0] {
        CFG_TIME_STEP  = 3'd0,
        CFG_RATE       = 3'd1,
        CFG_VOLATILITY = 3'd2,
        CFG_SPOT       = 3'd3,
        CFG_SCHEME     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic  sat;
        t_word value;
    } t_arith_res;

    // Signed Q multiply: truncate the magnitude, clamp to the word range
    function automatic t_arith_res mul_q(input t_word a, input t_word b);
        t_arith_res              res;
        logic                    neg;
        logic [WORD_W-1:0]       ua;
        logic [WORD_W-1:0]       ub;
        logic [PROD_W-1:0]       prod;
        logic [QUOT_W-1:0]       quot;
        logic [QUOT_W-1:0]       limit;
        neg   = a[WORD_W-1] ^ b[WORD_W-1];
        ua    = a[WORD_W-1] ? WORD_W'(-a) : WORD_W'(a);
        ub    = b[WORD_W-1] ? WORD_W'(-b) : WORD_W'(b);
        prod  = PROD_W'(ua) * PROD_W'(ub);
        quot  = prod[PROD_W-1:FRAC_W];
        limit = neg ? (QUOT_W'(1) << (WORD_W - 1)) : ((QUOT_W'(1) << (WORD_W - 1)) - 1'b1);
        res.sat = 1'b0;
        if (quot > limit) begin
            res.sat = 1'b1;
            quot    = limit;
        end
        res.value = neg ? t_word'(-quot[WORD_W-1:0]) : t_word'(quot[WORD_W-1:0]);
        return res;
    endfunction

endpackage

// File: rtl/gbm_euler_milstein_path_step_top.sv
// Top level of the GBM path step block: config registers, sequencer and one
// shared multiplier and saturating adder. Depends on gbm_pkg.
//
// Each input word carries a Brownian path value and produces one price word.
// A path-start word returns the spot price and records the Brownian value;
// every other word forms dW from the recorded value and advances the price
// by S*(r*dt) + (S*sigma)*dW, plus 0.5*(S*sigma^2)*(dW^2 - dt) in Milstein
// mode. One multiplier and one adder are reused step by step under a small
// sequencer, so the block takes one word at a time: a path-start word goes
// straight to the result step, an Euler step runs through a chain of 4
// dependent multiplies and a Milstein step through a chain of 9, all through
// the single multiplier, and the input is ready again once the result
// register has loaded. The result register lets a new word enter while the
// previous result waits; a result that is still held there stalls the
// sequencer in its last step. Any clamp along the way sets the saturated
// flag of that result. Configuration must be written only while no word is
// in flight; the block itself does not enforce this.
module gbm_euler_milstein_path_step_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [gbm_pkg::CADDR_W-1:0]   i_cfg_addr,
    input  logic [gbm_pkg::CFG_W-1:0]     i_cfg_wdata,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_path_start,
    input  logic signed [gbm_pkg::WORD_W-1:0] i_brownian_value,
    input  logic                          i_path_end,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [gbm_pkg::WORD_W-1:0] o_price,
    output logic                          o_last_of_path,
    output logic                          o_saturated
);
    import gbm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DW,
        ST_DRIFT,
        ST_SSG,
        ST_DIFF,
        ST_SUM,
        ST_SIG2,
        ST_HALF,
        ST_DWSQ,
        ST_CORR,
        ST_MCORR,
        ST_FINAL,
        ST_DONE
    } t_state;

    // configuration
    logic [DT_W-1:0]          r_time_step;
    logic signed [RATE_W-1:0] r_rate;
    logic [VOL_W-1:0]         r_volatility;
    logic [SPOT_W-1:0]        r_spot;
    logic                     r_scheme;

    // sequencer and datapath registers
    t_state r_state, n_state;
    t_word  r_prev_price, n_prev_price;
    t_word  r_prev_bw, n_prev_bw;
    t_word  r_bw, n_bw;
    logic   r_end, n_end;
    t_word  r_dw, n_dw;
    t_word  r_p, n_p;
    t_word  r_acc, n_acc;
    t_word  r_coef, n_coef;
    logic   r_flag, n_flag;
    logic   r_out_valid, n_out_valid;
    t_word  r_price, n_price;
    logic   r_last, n_last;
    logic   r_sat, n_sat;

    // shared unit controls
    logic       mul_en;
    t_word      mul_a, mul_b;
    t_arith_res mul_res;
    logic       add_en;
    t_word      add_a, add_b;
    logic       add_sub;
    t_word      add_nb;
    logic       add_neg_sat;
    logic [WORD_W:0] add_sum;
    t_arith_res add_res;

    t_word dt_w, rate_w, vol_w;
    logic  in_fire, out_free;

    assign dt_w   = {{(WORD_W-DT_W){1'b0}}, r_time_step};
    assign rate_w = {{(WORD_W-RATE_W){r_rate[RATE_W-1]}}, r_rate};
    assign vol_w  = {{(WORD_W-VOL_W){1'b0}}, r_volatility};

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_price        = r_price;
    assign o_last_of_path = r_last;
    assign o_saturated    = r_sat;

    // Select operands of the shared multiplier and adder for this step
    always_comb begin
        mul_en  = 1'b0;
        mul_a   = r_prev_price;
        mul_b   = r_p;
        add_en  = 1'b0;
        add_a   = r_acc;
        add_b   = r_p;
        add_sub = 1'b0;
        case (r_state)
            ST_DW: begin
                mul_en  = 1'b1;
                mul_a   = rate_w;
                mul_b   = dt_w;
                add_en  = 1'b1;
                add_a   = r_bw;
                add_b   = r_prev_bw;
                add_sub = 1'b1;
            end
            ST_DRIFT: begin
                mul_en = 1'b1;
            end
            ST_SSG: begin
                mul_en = 1'b1;
                mul_b  = vol_w;
                add_en = 1'b1;
                add_a  = r_prev_price;
            end
            ST_DIFF: begin
                mul_en = 1'b1;
                mul_a  = r_p;
                mul_b  = r_dw;
            end
            ST_SUM: begin
                add_en = 1'b1;
                mul_en = r_scheme;
                mul_a  = vol_w;
                mul_b  = vol_w;
            end
            ST_SIG2: begin
                mul_en = 1'b1;
            end
            ST_HALF: begin
                mul_en = 1'b1;
                mul_a  = r_p;
                mul_b  = HALF;
            end
            ST_DWSQ: begin
                mul_en = 1'b1;
                mul_a  = r_dw;
                mul_b  = r_dw;
            end
            ST_CORR: begin
                add_en  = 1'b1;
                add_a   = r_p;
                add_b   = dt_w;
                add_sub = 1'b1;
            end
            ST_MCORR: begin
                mul_en = 1'b1;
                mul_a  = r_coef;
                mul_b  = r_dw;
            end
            ST_FINAL: begin
                add_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
                add_en = 1'b0;
            end
        endcase
    end

    // Shared multiplier
    assign mul_res = mul_q(mul_a, mul_b);

    // Shared saturating adder, with saturating negate of the second operand
    always_comb begin
        add_neg_sat = 1'b0;
        add_nb      = add_b;
        if (add_sub) begin
            if (add_b == WORD_MIN) begin
                add_neg_sat = 1'b1;
                add_nb      = WORD_MAX;
            end else begin
                add_nb = -add_b;
            end
        end
        add_sum       = {add_a[WORD_W-1], add_a} + {add_nb[WORD_W-1], add_nb};
        add_res.sat   = add_neg_sat;
        add_res.value = add_sum[WORD_W-1:0];
        if (add_sum[WORD_W] != add_sum[WORD_W-1]) begin
            add_res.sat   = 1'b1;
            add_res.value = add_sum[WORD_W] ? WORD_MIN : WORD_MAX;
        end
    end

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state      = r_state;
        n_prev_price = r_prev_price;
        n_prev_bw    = r_prev_bw;
        n_bw         = r_bw;
        n_end        = r_end;
        n_dw         = r_dw;
        n_p          = r_p;
        n_acc        = r_acc;
        n_coef       = r_coef;
        n_flag       = r_flag;
        n_out_valid  = r_out_valid;
        n_price      = r_price;
        n_last       = r_last;
        n_sat        = r_sat;

        // drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (mul_en) begin
            n_p    = mul_res.value;
            n_flag = n_flag | mul_res.sat;
        end
        if (add_en) begin
            n_flag = n_flag | add_res.sat;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_bw   = i_brownian_value;
                    n_end  = i_path_end;
                    n_flag = 1'b0;
                    if (i_path_start) begin
                        n_acc   = {1'b0, r_spot};
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_DW;
                    end
                end
            end
            ST_DW: begin
                n_dw    = add_res.value;
                n_state = ST_DRIFT;
            end
            ST_DRIFT: begin
                n_state = ST_SSG;
            end
            ST_SSG: begin
                n_acc   = add_res.value;
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_acc   = add_res.value;
                n_state = r_scheme ? ST_SIG2 : ST_DONE;
            end
            ST_SIG2: begin
                n_state = ST_HALF;
            end
            ST_HALF: begin
                n_state = ST_DWSQ;
            end
            ST_DWSQ: begin
                n_coef  = r_p;
                n_state = ST_CORR;
            end
            ST_CORR: begin
                n_dw    = add_res.value;
                n_state = ST_MCORR;
            end
            ST_MCORR: begin
                n_state = ST_FINAL;
            end
            ST_FINAL: begin
                n_acc   = add_res.value;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register is free
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_price      = r_acc;
                    n_last       = r_end;
                    n_sat        = r_flag;
                    n_prev_price = r_acc;
                    n_prev_bw    = r_bw;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_time_step  <= '0;
            r_rate       <= '0;
            r_volatility <= '0;
            r_spot       <= SPOT_RESET;
            r_scheme     <= 1'b0;
            r_prev_price <= '0;
            r_prev_bw    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev_price <= n_prev_price;
            r_prev_bw    <= n_prev_bw;
            r_out_valid  <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_TIME_STEP:  r_time_step  <= i_cfg_wdata[DT_W-1:0];
                    CFG_RATE:       r_rate       <= i_cfg_wdata[RATE_W-1:0];
                    CFG_VOLATILITY: r_volatility <= i_cfg_wdata[VOL_W-1:0];
                    CFG_SPOT:       r_spot       <= i_cfg_wdata[SPOT_W-1:0];
                    CFG_SCHEME:     r_scheme     <= i_cfg_wdata[0];
                    default:        r_scheme     <= r_scheme;
                endcase
            end
        end
        r_bw    <= n_bw;
        r_end   <= n_end;
        r_dw    <= n_dw;
        r_p     <= n_p;
        r_acc   <= n_acc;
        r_coef  <= n_coef;
        r_flag  <= n_flag;
        r_price <= n_price;
        r_last  <= n_last;
        r_sat   <= n_sat;
    end

    // A path-start word goes straight to the result step carrying the spot price
    a_start_spot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_path_start) |=>
            (r_state == ST_DONE) && (r_acc == {1'b0, $past(r_spot)}))
        else $error("path start did not load the spot price");

    // An Euler step ends after the final sum
    a_euler_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM && !r_scheme) |=> (r_state == ST_DONE))
        else $error("Euler step ran past the final sum");

    // A delivered result and the stored price agree
    a_result_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=>
            (o_out_valid && (o_price == r_prev_price) && (r_state == ST_IDLE)))
        else $error("result and stored price differ");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for gbm_euler_milstein_path_step_top: drives Brownian path words,
// predicts each price word in fixed point and checks the result stream.
// Depends on gbm_pkg and the top level only.
module testbench;

    import gbm_pkg::*;

    localparam int  CYCLE_LIMIT     = 400000;
    localparam int  SETTLE_CYCLES   = 16;
    localparam int  RANDOM_PHASES   = 8;
    localparam int  WORDS_PER_PHASE = 150;
    localparam logic SCHEME_EULER    = 1'b0;
    localparam logic SCHEME_MILSTEIN = 1'b1;
    localparam logic signed [WORD_W:0] WIDE_MAX = 33'sd2147483647;
    localparam logic signed [WORD_W:0] WIDE_MIN = -33'sd2147483648;

    typedef struct packed {
        t_word price;
        logic  last_of_path;
        logic  saturated;
    } t_price_word;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_wr_en      = 1'b0;
    logic [CADDR_W-1:0]   i_cfg_addr       = '0;
    logic [CFG_W-1:0]     i_cfg_wdata      = '0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_ready;
    logic                 i_path_start     = 1'b0;
    t_word                i_brownian_value = '0;
    logic                 i_path_end       = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready      = 1'b0;
    t_word                o_price;
    logic                 o_last_of_path;
    logic                 o_saturated;

    // Predictor copy of the registers and the path state
    logic [DT_W-1:0]      cur_dt     = '0;
    logic [RATE_W-1:0]    cur_rate   = '0;
    logic [VOL_W-1:0]     cur_vol    = '0;
    logic [SPOT_W-1:0]    cur_spot   = SPOT_RESET;
    logic                 cur_scheme = SCHEME_EULER;
    t_word                model_price    = '0;
    t_word                model_brownian = '0;
    bit                   clamp_hit;

    t_price_word          expected_prices[$];
    int                   fail_count     = 0;
    int                   cycle_count    = 0;
    int                   words_sent     = 0;
    int                   burst_left     = 0;
    int                   send_gap_max   = 0;
    int                   rx_stall_max   = 0;
    int                   rx_left        = 0;
    bit                   rx_stalling    = 1'b0;

    gbm_euler_milstein_path_step_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_path_start     (i_path_start),
        .i_brownian_value (i_brownian_value),
        .i_path_end       (i_path_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_price          (o_price),
        .o_last_of_path   (o_last_of_path),
        .o_saturated      (o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the predictor; every clamp marks clamp_hit
    // ------------------------------------------------------------------
    function automatic t_word clamp_word(input logic signed [WORD_W:0] x);
        t_word r;
        if (x > WIDE_MAX) begin
            clamp_hit = 1'b1;
            r = WORD_MAX;
        end else if (x < WIDE_MIN) begin
            clamp_hit = 1'b1;
            r = WORD_MIN;
        end else begin
            r = t_word'(x[WORD_W-1:0]);
        end
        return r;
    endfunction

    function automatic t_word add_word(input t_word a, input t_word b);
        logic signed [WORD_W:0] s;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        return clamp_word(s);
    endfunction

    function automatic t_word negate_word(input t_word a);
        logic signed [WORD_W:0] s;
        s = 33'd0 - {a[WORD_W-1], a};
        return clamp_word(s);
    endfunction

    // Multiply magnitudes, drop the fraction bits, clamp, then restore sign
    function automatic t_word mul_word(input t_word a, input t_word b);
        logic                    negative;
        logic [WORD_W-1:0]       mag_a;
        logic [WORD_W-1:0]       mag_b;
        logic [2*WORD_W-1:0]     full;
        logic [2*WORD_W-FRAC_W-1:0] scaled;
        logic [2*WORD_W-FRAC_W-1:0] bound;
        negative = a[WORD_W-1] ^ b[WORD_W-1];
        mag_a    = a[WORD_W-1] ? -a : a;
        mag_b    = b[WORD_W-1] ? -b : b;
        full     = {{WORD_W{1'b0}}, mag_a} * {{WORD_W{1'b0}}, mag_b};
        scaled   = full[2*WORD_W-1:FRAC_W];
        bound    = negative ? 44'h0_8000_0000 : 44'h0_7FFF_FFFF;
        if (scaled > bound) begin
            clamp_hit = 1'b1;
            scaled    = bound;
        end
        return negative ? t_word'(-scaled[WORD_W-1:0]) : t_word'(scaled[WORD_W-1:0]);
    endfunction

    // Advance the predicted path by one word and return the expected price word
    function automatic t_price_word step_price(input logic start, input t_word bw,
                                               input logic last);
        t_price_word res;
        t_word s, dt, r, sg, dw, drift, diffusion, sig2, coef, corr, price;
        clamp_hit = 1'b0;
        if (start) begin
            price = {1'b0, cur_spot};
        end else begin
            s         = model_price;
            dt        = {{(WORD_W-DT_W){1'b0}}, cur_dt};
            r         = $signed(cur_rate);
            sg        = {{(WORD_W-VOL_W){1'b0}}, cur_vol};
            dw        = add_word(bw, negate_word(model_brownian));
            drift     = mul_word(s, mul_word(r, dt));
            diffusion = mul_word(mul_word(s, sg), dw);
            price     = add_word(add_word(s, drift), diffusion);
            if (cur_scheme == SCHEME_MILSTEIN) begin
                sig2  = mul_word(sg, sg);
                coef  = mul_word(mul_word(s, sig2), HALF);
                corr  = add_word(mul_word(dw, dw), negate_word(dt));
                price = add_word(price, mul_word(coef, corr));
            end
        end
        model_price      = price;
        model_brownian   = bw;
        res.price        = price;
        res.last_of_path = last;
        res.saturated    = clamp_hit;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Send one path word in bursts with random gaps; predict on acceptance
    task automatic send_word(input logic start, input t_word bw, input logic last);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
            if (gap > 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_path_start     = start;
        i_brownian_value = bw;
        i_path_end       = last;
        i_in_valid       = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        expected_prices.push_back(step_price(start, bw, last));
        words_sent++;
    endtask

    // Drop valid and wait until every expected price word has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_prices.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register (block idle) and mirror it into the predictor
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            CFG_TIME_STEP:  cur_dt     = data[DT_W-1:0];
            CFG_RATE:       cur_rate   = data[RATE_W-1:0];
            CFG_VOLATILITY: cur_vol    = data[VOL_W-1:0];
            CFG_SPOT:       cur_spot   = data[SPOT_W-1:0];
            CFG_SCHEME:     cur_scheme = data[0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int dt, input int rate, input int vol,
                             input int spot, input logic scheme);
        write_reg(CFG_TIME_STEP, CFG_W'(dt));
        write_reg(CFG_RATE, CFG_W'(rate));
        write_reg(CFG_VOLATILITY, CFG_W'(vol));
        write_reg(CFG_SPOT, CFG_W'(spot));
        write_reg(CFG_SCHEME, CFG_W'(scheme));
    endtask

    // Receiver: alternate runs of ready and runs of stall
    always @(negedge i_clk) begin
        if (rx_stall_max == 0) begin
            i_out_ready = 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_stalling = !rx_stalling;
                rx_left = rx_stalling ? $urandom_range(1, rx_stall_max)
                                      : $urandom_range(1, 10);
            end
            rx_left--;
            i_out_ready = !rx_stalling;
        end
    end

    // Compare each accepted price word with the oldest prediction
    always @(posedge i_clk) begin
        t_price_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_prices.size() == 0) begin
                $error("unexpected price word: price %0d", o_price);
                fail_count++;
            end else begin
                want = expected_prices.pop_front();
                if (o_price !== want.price) begin
                    $error("price: expected %0d, got %0d", want.price, o_price);
                    fail_count++;
                end
                if (o_last_of_path !== want.last_of_path) begin
                    $error("last_of_path: expected %0b, got %0b",
                           want.last_of_path, o_last_of_path);
                    fail_count++;
                end
                if (o_saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b", want.saturated, o_saturated);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values: a step before any path start stays at zero, spot is 1.0
    task automatic test_reset_state();
        send_word(1'b0, 32'sh0012_3456, 1'b0);
        send_word(1'b1, WORD_MIN, 1'b0);
        send_word(1'b0, WORD_MAX, 1'b1);
        // path end does not break the path
        send_word(1'b0, '0, 1'b0);
        wait_drained();
    endtask

    // Euler scheme at the register maxima, then at the minima, then at nominal values
    task automatic test_euler_extremes();
        write_all('h1F_FFFF, 'h1F_FFFF, 'h7F_FFFF, 'h7FFF_FFFF, SCHEME_EULER);
        send_word(1'b1, '0, 1'b0);
        send_word(1'b0, 32'sh0010_0000, 1'b0);
        send_word(1'b0, -32'sh0010_0000, 1'b0);
        send_word(1'b0, WORD_MAX, 1'b1);
        wait_drained();
        write_all(0, -(1 << 21), 0, 0, SCHEME_EULER);
        send_word(1'b1, WORD_MAX, 1'b0);
        send_word(1'b0, WORD_MIN, 1'b0);
        send_word(1'b0, -1, 1'b1);
        wait_drained();
        write_all(1 << 20, -(1 << 20), 1 << 22, 100 << 20, SCHEME_EULER);
        send_word(1'b1, '0, 1'b0);
        send_word(1'b0, 32'sh0000_4000, 1'b0);
        send_word(1'b0, -32'sh0000_8000, 1'b1);
        wait_drained();
    endtask

    // Milstein correction with realistic values, then with saturating ones
    task automatic test_milstein();
        write_all(20165, 52429, 209715, 100 << 20, SCHEME_MILSTEIN);
        send_word(1'b1, '0, 1'b0);
        send_word(1'b0, 32'sh0002_0000, 1'b0);
        send_word(1'b0, -32'sh0001_0000, 1'b0);
        send_word(1'b0, 32'sh0000_8000, 1'b1);
        wait_drained();
        write_all('h1F_FFFF, 1 << 20, 'h7F_FFFF, 'h7FFF_FFFF, SCHEME_MILSTEIN);
        send_word(1'b1, 32'sh0001_0000, 1'b0);
        send_word(1'b0, 32'sh0001_0000, 1'b0);
        send_word(1'b0, WORD_MIN, 1'b1);
        wait_drained();
    endtask

    // Random paths across several register settings and idling patterns
    task automatic test_random_paths();
        int first, len, walk, spread, roll;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0)
                write_all('h1F_FFFF, 'h1F_FFFF, 'h7F_FFFF, 'h7FFF_FFFF,
                          SCHEME_MILSTEIN);
            else if (p == 1)
                write_all(0, -(1 << 21), 0, 0, SCHEME_EULER);
            else if (p == RANDOM_PHASES - 1)
                write_all($urandom, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)));
            else
                write_all($urandom_range(1 << 12, 1 << 19),
                          int'($urandom_range(0, 419430)) - 209715,
                          $urandom_range(0, 1 << 20),
                          $urandom_range(1 << 20, 300 << 20),
                          p[0]);
            send_gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 6);
            rx_stall_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 12);
            spread = 1 << $urandom_range(12, 19);
            first  = words_sent;
            while (words_sent - first < WORDS_PER_PHASE) begin
                roll = $urandom_range(0, 99);
                if (roll < 85) begin
                    // well-formed path
                    len  = $urandom_range(2, 20);
                    walk = int'($urandom_range(0, 1 << 21)) - (1 << 20);
                    for (int k = 0; k < len; k++) begin
                        if (k > 0)
                            walk += int'($urandom_range(0, 2 * spread)) - spread;
                        send_word(k == 0, walk, k == len - 1);
                    end
                end else if (roll < 93) begin
                    // noise word
                    send_word(1'($urandom_range(0, 1)), $urandom,
                              1'($urandom_range(0, 1)));
                end else begin
                    // continue the current path with no start and random ends
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                        send_word(1'b0, $urandom, 1'($urandom_range(0, 1)));
                end
                // hold off mid-phase until the block has drained
                if (p == 3 && words_sent - first >= WORDS_PER_PHASE / 2 &&
                    words_sent - first < WORDS_PER_PHASE / 2 + 2)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_state();
        test_euler_extremes();
        test_milstein();
        test_random_paths();
        wait_drained();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
